// File: rtl/rcds_pkg.sv
package rcds_pkg;

    // Field widths of the ray setup datapath.
    localparam int COL_W    = 10;
    localparam int POS_W    = 20;
    localparam int DIR_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 20;
    localparam int CAM_NW   = COL_W + 13;    // numerator of the camera divide
    localparam int CAM_W    = CAM_NW + 1;    // signed camera coordinate
    localparam int PRD_W    = DIR_W + CAM_W; // plane times camera product
    localparam int RAY_W    = 17;
    localparam int SQ_W     = 2 * RAY_W;     // sum of the two squares
    localparam int RAD_W    = SQ_W + 24;     // radicand, even width
    localparam int ROOT_W   = RAD_W / 2;
    localparam int DIST_W   = 24;
    localparam int FRAC_W   = 13;
    localparam int SIDE_PW  = FRAC_W + DIST_W;
    localparam int OUT_W    = 2 * 8 + 2 + 2 * RAY_W + 4 * DIST_W;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0]       DIST_MAX = '1;
    localparam logic signed [CAM_W-1:0] CAM_ONE  = CAM_W'(4096);
    localparam logic [FRAC_W-1:0]       FRAC_ONE = FRAC_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X      = 3'd0,
        REG_POS_Y      = 3'd1,
        REG_VIEW_DIR_X = 3'd2,
        REG_VIEW_DIR_Y = 3'd3,
        REG_PLANE_X    = 3'd4,
        REG_PLANE_Y    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [RAY_W-1:0] rx;
        logic signed [RAY_W-1:0] ry;
        logic [RAY_W-1:0]        ax;
        logic [RAY_W-1:0]        ay;
    } ray_info_t;

    // Direction plus the Q.12 product, rounded toward minus infinity and saturated.
    function automatic logic signed [RAY_W-1:0] sat_ray(
        input logic signed [DIR_W-1:0] dir,
        input logic signed [PRD_W-1:0] prod
    );
        logic signed [PRD_W-12:0] s;
        s = (PRD_W-11)'(dir) + (PRD_W-11)'(prod >>> 12);
        if (s < -(PRD_W-11)'(65536))
            return {1'b1, {(RAY_W-1){1'b0}}};
        else if (s > (PRD_W-11)'(65535))
            return {1'b0, {(RAY_W-1){1'b1}}};
        else
            return s[RAY_W-1:0];
    endfunction

    function automatic logic [RAY_W-1:0] abs_ray(input logic signed [RAY_W-1:0] r);
        return r[RAY_W-1] ? RAY_W'(~r + 1'b1) : RAY_W'(r);
    endfunction

endpackage

// File: rtl/ray_column_dda_setup.sv
// Throughput: one column per clock while the skid entry is empty; the camera divide is a
// reciprocal multiply, and the fully pipelined square root and two delta divides each
// retire one bit per stage.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and the output
// buffer and loads the configuration registers with their reset defaults.
module ray_column_dda_setup
    import rcds_pkg::*;
#(
    parameter int SCREEN_WIDTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream. s_tdata: column [9:0], zero fill [15:10].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // Output stream. m_tdata from bit 0 up: cell_x [7:0], cell_y [15:8], step_x_neg [16],
    // step_y_neg [17], ray_x [34:18], ray_y [51:35], delta_x [75:52], delta_y [99:76],
    // side_x [123:100], side_y [147:124], zero fill [151:148].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // Register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Camera divide by reciprocal: floor(n / SCREEN_WIDTH) for n = column * 8192 below
    // 2^CAM_NW equals (n * CAM_RCP) >> CAM_S with CAM_RCP = ceil(2^CAM_S / SCREEN_WIDTH).
    // The reciprocal never exceeds 2^24, and the 13 zero bits of n fold into the shift.
    localparam int     CAM_L     = $clog2(SCREEN_WIDTH);
    localparam int     CAM_S     = CAM_NW + CAM_L;
    localparam int     CAM_SH    = CAM_S - 13;
    localparam int     RCP_W     = CAM_NW + 2;
    localparam int     CPRD_W    = COL_W + RCP_W;
    localparam longint CAM_RCP_L = ((longint'(1) << CAM_S) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam logic [RCP_W-1:0] CAM_RCP = RCP_W'(CAM_RCP_L);

    // Stage map: input capture, camera multiply, three ray stages, two square
    // stages, ROOT_W+1 root registers, ROOT_W+1 divide registers, three side stages.
    localparam int NSTG = 1 + 1 + 3 + 2 + (ROOT_W + 1) + (ROOT_W + 1) + 3;

    // Configuration registers.
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    // The whole pipeline advances together; the flag comes straight from a flop, so ready is registered.
    logic            en;
    logic [NSTG-1:0] vld_reg;

    // Camera divide: captured column and its product with the reciprocal.
    logic [COL_W-1:0]  col_reg;
    logic [CPRD_W-1:0] cprd_reg;

    // Ray stages.
    logic signed [CAM_W-1:0] cam_reg;
    logic signed [PRD_W-1:0] prd_x_reg, prd_y_reg;
    logic signed [RAY_W-1:0] ray_x_reg, ray_y_reg;
    ray_info_t               c1_reg, c2_reg;
    logic [SQ_W-1:0]         sq_x_reg, sq_y_reg;

    // Square root of (ax^2 + ay^2) << 24, two radicand bits per stage.
    logic [RAD_W-1:0]  sn_reg [0:ROOT_W];
    logic [ROOT_W+1:0] sr_reg [0:ROOT_W];
    logic [ROOT_W-1:0] sroot_reg [0:ROOT_W];
    ray_info_t         si_reg [0:ROOT_W];

    // Delta divides: root / |ray| on both axes, sharing the numerator shifter.
    logic [ROOT_W-1:0] dn_reg [0:ROOT_W];
    logic [RAY_W-1:0]  dxr_reg [0:ROOT_W];
    logic [RAY_W-1:0]  dyr_reg [0:ROOT_W];
    logic [ROOT_W-1:0] dxq_reg [0:ROOT_W];
    logic [ROOT_W-1:0] dyq_reg [0:ROOT_W];
    ray_info_t         di_reg [0:ROOT_W];

    // Side distance stages.
    ray_info_t          e1_reg, e2_reg;
    logic [DIST_W-1:0]  e1_dx_reg, e1_dy_reg, e2_dx_reg, e2_dy_reg;
    logic [FRAC_W-1:0]  e1_fx_reg, e1_fy_reg;
    logic               e1_zx_reg, e1_zy_reg, e2_zx_reg, e2_zy_reg;
    logic [SIDE_PW-1:0] e2_px_reg, e2_py_reg;
    logic [OUT_W-1:0]   e3_reg;

    // Output register with a skid entry behind it.
    logic [OUT_W-1:0] out_reg, skid_reg;
    logic             out_v_reg, skid_v_reg;
    logic             inc_v;

    logic [DIST_W-1:0] dx_next, dy_next, sx_next, sy_next;
    logic [FRAC_W-1:0] fx_next, fy_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= DIR_W'(4096);
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= DIR_W'(2703);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POS_X:      pos_x_reg   <= cfg_data;
                REG_POS_Y:      pos_y_reg   <= cfg_data;
                REG_VIEW_DIR_X: dir_x_reg   <= cfg_data[DIR_W-1:0];
                REG_VIEW_DIR_Y: dir_y_reg   <= cfg_data[DIR_W-1:0];
                REG_PLANE_X:    plane_x_reg <= cfg_data[DIR_W-1:0];
                REG_PLANE_Y:    plane_y_reg <= cfg_data[DIR_W-1:0];
                default:        ;
            endcase
        end
    end

    // The pipeline stops only while the skid entry is full, so nothing is lost
    // when the downstream side holds off.
    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign inc_v    = vld_reg[NSTG-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
    end

    // Input capture and the reciprocal product of the camera divide.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg  <= s_tdata[COL_W-1:0];
            cprd_reg <= col_reg * CAM_RCP;
        end
    end

    // Camera coordinate, plane products, ray directions, magnitudes, squares and the root inputs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cam_reg   <= $signed({1'b0, CAM_NW'(cprd_reg >> CAM_SH)}) - CAM_ONE;
            prd_x_reg <= plane_x_reg * cam_reg;
            prd_y_reg <= plane_y_reg * cam_reg;
            ray_x_reg <= sat_ray(dir_x_reg, prd_x_reg);
            ray_y_reg <= sat_ray(dir_y_reg, prd_y_reg);
            c1_reg.rx <= ray_x_reg;
            c1_reg.ry <= ray_y_reg;
            c1_reg.ax <= abs_ray(ray_x_reg);
            c1_reg.ay <= abs_ray(ray_y_reg);
            sq_x_reg  <= SQ_W'(c1_reg.ax) * SQ_W'(c1_reg.ax);
            sq_y_reg  <= SQ_W'(c1_reg.ay) * SQ_W'(c1_reg.ay);
            c2_reg    <= c1_reg;
            sn_reg[0]    <= {sq_x_reg + sq_y_reg, 24'b0};
            sr_reg[0]    <= '0;
            sroot_reg[0] <= '0;
            si_reg[0]    <= c2_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        logic [ROOT_W+3:0] rem2;
        logic [ROOT_W+3:0] trial;
        assign rem2  = {sr_reg[k], sn_reg[k][RAD_W-1:RAD_W-2]};
        assign trial = {2'b00, sroot_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sn_reg[k+1] <= sn_reg[k] << 2;
                si_reg[k+1] <= si_reg[k];
                if (rem2 >= trial)
                begin
                    sr_reg[k+1]    <= (ROOT_W+2)'(rem2 - trial);
                    sroot_reg[k+1] <= {sroot_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sr_reg[k+1]    <= rem2[ROOT_W+1:0];
                    sroot_reg[k+1] <= {sroot_reg[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_reg[0]  <= sroot_reg[ROOT_W];
            dxr_reg[0] <= '0;
            dyr_reg[0] <= '0;
            dxq_reg[0] <= '0;
            dyq_reg[0] <= '0;
            di_reg[0]  <= si_reg[ROOT_W];
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_div
        logic [RAY_W:0] tx, ty;
        assign tx = {dxr_reg[k], dn_reg[k][ROOT_W-1]};
        assign ty = {dyr_reg[k], dn_reg[k][ROOT_W-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dn_reg[k+1] <= dn_reg[k] << 1;
                di_reg[k+1] <= di_reg[k];
                if (tx >= {1'b0, di_reg[k].ax})
                begin
                    dxr_reg[k+1] <= RAY_W'(tx - {1'b0, di_reg[k].ax});
                    dxq_reg[k+1] <= {dxq_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    dxr_reg[k+1] <= tx[RAY_W-1:0];
                    dxq_reg[k+1] <= {dxq_reg[k][ROOT_W-2:0], 1'b0};
                end
                if (ty >= {1'b0, di_reg[k].ay})
                begin
                    dyr_reg[k+1] <= RAY_W'(ty - {1'b0, di_reg[k].ay});
                    dyq_reg[k+1] <= {dyq_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    dyr_reg[k+1] <= ty[RAY_W-1:0];
                    dyq_reg[k+1] <= {dyq_reg[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // A zero ray component has no crossing on its axis, so both distances saturate.
    always_comb
    begin
        if (di_reg[ROOT_W].ax == '0 || dxq_reg[ROOT_W] > ROOT_W'(DIST_MAX))
            dx_next = DIST_MAX;
        else
            dx_next = dxq_reg[ROOT_W][DIST_W-1:0];
        if (di_reg[ROOT_W].ay == '0 || dyq_reg[ROOT_W] > ROOT_W'(DIST_MAX))
            dy_next = DIST_MAX;
        else
            dy_next = dyq_reg[ROOT_W][DIST_W-1:0];
        // A negative ray meets the grid line below the position, else the one above.
        fx_next = di_reg[ROOT_W].rx[RAY_W-1] ? FRAC_W'(pos_x_reg[11:0])
                                             : FRAC_ONE - FRAC_W'(pos_x_reg[11:0]);
        fy_next = di_reg[ROOT_W].ry[RAY_W-1] ? FRAC_W'(pos_y_reg[11:0])
                                             : FRAC_ONE - FRAC_W'(pos_y_reg[11:0]);
        if (e2_zx_reg || e2_px_reg[SIDE_PW-1:12] > (SIDE_PW-12)'(DIST_MAX))
            sx_next = DIST_MAX;
        else
            sx_next = e2_px_reg[DIST_W+11:12];
        if (e2_zy_reg || e2_py_reg[SIDE_PW-1:12] > (SIDE_PW-12)'(DIST_MAX))
            sy_next = DIST_MAX;
        else
            sy_next = e2_py_reg[DIST_W+11:12];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg    <= di_reg[ROOT_W];
            e1_dx_reg <= dx_next;
            e1_dy_reg <= dy_next;
            e1_fx_reg <= fx_next;
            e1_fy_reg <= fy_next;
            e1_zx_reg <= di_reg[ROOT_W].ax == '0;
            e1_zy_reg <= di_reg[ROOT_W].ay == '0;
            e2_reg    <= e1_reg;
            e2_dx_reg <= e1_dx_reg;
            e2_dy_reg <= e1_dy_reg;
            e2_zx_reg <= e1_zx_reg;
            e2_zy_reg <= e1_zy_reg;
            e2_px_reg <= SIDE_PW'(e1_fx_reg) * SIDE_PW'(e1_dx_reg);
            e2_py_reg <= SIDE_PW'(e1_fy_reg) * SIDE_PW'(e1_dy_reg);
            e3_reg    <= {sy_next, sx_next, e2_dy_reg, e2_dx_reg, e2_reg.ry, e2_reg.rx,
                          e2_reg.ry[RAY_W-1], e2_reg.rx[RAY_W-1],
                          pos_y_reg[POS_W-1:12], pos_x_reg[POS_W-1:12]};
        end
    end

    // Output side: the skid entry catches the one transfer that leaves the pipeline
    // in the cycle the output register is found stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= inc_v;
        end
        else if (inc_v)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
            out_reg <= skid_v_reg ? skid_reg : e3_reg;
        else if (inc_v)
            skid_reg <= e3_reg;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(TDATA_OUT_W-OUT_W){1'b0}}, out_reg};

endmodule

// File: rtl/rcds_check.sv
module rcds_check
    import rcds_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // A stalled result holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result changed while stalled");

    // The step sign agrees with the sign of the ray.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16] == m_tdata[34] && m_tdata[17] == m_tdata[51])
        else $error("step sign disagrees with ray sign");

    // A zero x ray saturates both x distances.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:18] == '0 |->
            m_tdata[75:52] == DIST_MAX && m_tdata[123:100] == DIST_MAX)
        else $error("zero ray x without saturated distances");

    // Input back-pressure only follows a stalled output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input ready dropped without output stall");

endmodule

bind ray_column_dda_setup rcds_check u_rcds_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
